/* design/lrupr_pkg.sv */
// Package with the constants, item types and command struct of the LRU page replacement block.
package lrupr_pkg;

  // Frame store geometry.
  localparam int FRAMES     = 8;
  localparam int PAGE_WIDTH = 16;
  localparam int IDX_W      = $clog2(FRAMES);
  localparam int CNT_W      = 4;
  localparam int FAULT_W    = 16;

  // Configuration register map.
  localparam int          ADDR_W       = 3;
  localparam logic [0:0]  REG_FRAMES   = 1'b0;
  localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(8);

  // One page reference.
  typedef struct packed {
    logic [PAGE_WIDTH-1:0] page;
    logic                  last_ref;
  } in_t;

  // One replacement result.
  typedef struct packed {
    logic                  hit;
    logic [2:0]            frame_index;
    logic                  evicted_valid;
    logic [PAGE_WIDTH-1:0] evicted_page;
    logic [FAULT_W-1:0]    fault_count;
    logic                  last_out;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

/* design/lrupr_ctrl.sv */
// Controller state machine that sequences lookup and commit of each page reference.
module lrupr_ctrl import lrupr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, commit;

  // An item is taken only while no reference is being looked up.
  assign accept = in_valid_i && (state_q == ST_IDLE);
  // The result is committed once the output register is free or being emptied.
  assign commit = (state_q == ST_LOOK) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag follows loads and takes of the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;

endmodule

/* design/lrupr_dp.sv */
// Datapath with frame store, recency ranks, fault counter and result register.
module lrupr_dp import lrupr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  in_t              in_data_i,
  input  logic [CNT_W-1:0] frames_in_use_i,
  output out_t             out_data_o
);

  in_t                   in_q;
  out_t                  out_q;
  logic [PAGE_WIDTH-1:0] page_q  [FRAMES];
  logic                  valid_q [FRAMES];
  logic [IDX_W-1:0]      rank_q  [FRAMES];
  logic [FAULT_W-1:0]    faults_q;

  logic [CNT_W-1:0]      active;
  logic [FRAMES-1:0]     in_use;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic                  found_empty;
  logic [IDX_W-1:0]      empty_idx;
  logic [IDX_W-1:0]      lru_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic                  evict;
  logic [FAULT_W-1:0]    faults_next;

  // Input item register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
  end

  // Clamp the configured frame count to the range 1 to FRAMES.
  always_comb begin
    active = frames_in_use_i;
    if (frames_in_use_i == '0) active = CNT_W'(1);
    if (frames_in_use_i > CNT_W'(FRAMES)) active = CNT_W'(FRAMES);
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i] = (CNT_W'(i) < active);
    end
  end

  // Tag compare, first empty frame and least recent frame over the active frames.
  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    found_empty = 1'b0;
    empty_idx   = '0;
    lru_idx     = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (in_use[i] && valid_q[i] && page_q[i] == in_q.page) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (in_use[i] && !valid_q[i]) begin
        found_empty = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
    for (int i = 1; i < FRAMES; i++) begin
      if (in_use[i] && rank_q[i] < rank_q[lru_idx]) lru_idx = IDX_W'(i);
    end
    evict   = !hit && !found_empty;
    sel_idx = hit ? hit_idx : (found_empty ? empty_idx : lru_idx);
  end

  // Fault count saturates at its maximum.
  always_comb begin
    faults_next = faults_q;
    if (!hit && faults_q != '1) faults_next = faults_q + FAULT_W'(1);
  end

  // Frame payload, written on a fault.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit) page_q[sel_idx] <= in_q.page;
  end

  // Valid bits, ranks and fault count; cleared after the last reference of a string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= IDX_W'(i);
      end
      faults_q <= '0;
    end else if (cmd_i.commit) begin
      if (in_q.last_ref) begin
        for (int i = 0; i < FRAMES; i++) begin
          valid_q[i] <= 1'b0;
          rank_q[i]  <= IDX_W'(i);
        end
        faults_q <= '0;
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (IDX_W'(i) == sel_idx) begin
            rank_q[i] <= IDX_W'(FRAMES - 1);
          end else if (rank_q[i] > rank_q[sel_idx]) begin
            rank_q[i] <= rank_q[i] - IDX_W'(1);
          end
        end
        valid_q[sel_idx] <= 1'b1;
        faults_q         <= faults_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.hit           <= hit;
      out_q.frame_index   <= 3'(sel_idx);
      out_q.evicted_valid <= evict;
      out_q.evicted_page  <= evict ? page_q[sel_idx] : '0;
      out_q.fault_count   <= faults_next;
      out_q.last_out      <= in_q.last_ref;
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/lru_page_replacement.sv */
// Top level of the fully associative LRU page replacement block.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o    in_data_i  (page, last_ref)
//   out      output     out_valid_o/out_stall_i  out_data_o (hit .. last_out)
//   cfg      input      APB write/read         frames_in_use at address 0
//
// Each item is handled in two steps: the reference is registered, then the parallel
// tag compare, victim select and update of frames, ranks and fault count run.
// The result register lets the next item enter while a result waits to be taken.
// Reset empties all frames, sets ranks to the frame index and frames_in_use to 8.
// A stalled output holds the lookup stage until the result register frees up.
module lru_page_replacement import lrupr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CNT_W-1:0] frames_in_use_q;
  dp_cmd_t          cmd;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES) begin
      frames_in_use_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAMES) ? {{(32 - CNT_W){1'b0}}, frames_in_use_q} : '0;

  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lrupr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_data_i       (in_data_i),
    .frames_in_use_i (frames_in_use_q),
    .out_data_o      (out_data_o)
  );

endmodule
